FILE: rtl/assert_macros.svh
// assertion macros used by the top rtl file of the sorted insert priority queue
// depends on nothing; the including module must provide clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define SPQ_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("assertion failed");

// condition must hold in the cycle after the trigger
`define SPQ_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

FILE: rtl/spq_pkg.sv
// types and constants of the sorted insert priority queue
// depends on nothing
package spq_pkg;

  localparam int DATA_W  = 32;
  localparam int DEPTH_W = 5;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_ENCODE = 1'b1
  } fsm_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic                     push_en;
    logic                     pop_en;
    logic signed [DATA_W-1:0] key;
  } cell_ctrl_t;

endpackage

FILE: rtl/sorted_insert_priority_queue.sv
// sorted insert priority queue: a min queue of signed 32-bit values held in a
// row of CAPACITY cells kept in ascending order. every cell compares its value
// with the pushed value in parallel, and the row shifts right behind the
// insertion point on push and left by one on pop, so the store update does not
// depend on the fill level. a request is taken in the idle state; the encode
// state then encodes the one-hot insertion point into the depth and loads the
// output register once that register is free or being read. a new request is
// taken while the previous result still waits in the output register. pushes
// into a full queue report full, pops on an empty queue report empty; no
// clearing pass is needed after reset since the cells are not reset and the
// fill count alone marks which of them hold values.
// depends on spq_pkg, spq_cell, spq_depth_enc and assert_macros.svh
`include "assert_macros.svh"

module sorted_insert_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic signed [spq_pkg::DATA_W-1:0] in_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic signed [spq_pkg::DATA_W-1:0] out_value_out,
  output logic [spq_pkg::DEPTH_W-1:0]       out_depth
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);  // fill count width
  localparam int IW = $clog2(CAPACITY);      // position width

  fsm_t state_r, state_nxt;

  logic [CW-1:0]            count_r, count_nxt;
  status_t                  status_r;
  logic signed [DATA_W-1:0] pop_value_r;
  logic [CAPACITY-1:0]      hit_r;

  logic                     out_valid_r;
  status_t                  out_status_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic [DEPTH_W-1:0]       out_depth_r;

  logic                     accept;
  logic                     is_full;
  logic                     is_empty;
  logic                     load_out;
  cell_ctrl_t               ctrl;

  logic signed [DATA_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]      cell_lt;
  logic [CAPACITY-1:0]      cell_hit;

  logic [IW-1:0]            pos;
  logic [IW+DEPTH_W-1:0]    pos_ext;

  assign accept   = in_valid && in_ready;
  assign is_full  = (count_r == CW'(CAPACITY));
  assign is_empty = (count_r == '0);

  // broadcast to the cell row; full and empty requests leave the row alone
  assign ctrl.push_en = accept && (in_op == OP_PUSH) && !is_full;
  assign ctrl.pop_en  = accept && (in_op == OP_POP) && !is_empty;
  assign ctrl.key     = in_value;

  // cell row: cell 0 holds the smallest value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     occ;
    logic                     prev_lt;
    logic signed [DATA_W-1:0] prev_value;
    logic signed [DATA_W-1:0] next_value;

    assign occ = (CW'(i) < count_r);

    if (i == 0) begin : g_first
      // nothing in front of the head cell, so it is always a candidate spot
      assign prev_lt    = 1'b1;
      assign prev_value = in_value;
    end else begin : g_mid
      assign prev_lt    = cell_lt[i-1];
      assign prev_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      // tail value is unused after a pop, it falls outside the fill count
      assign next_value = cell_value[i];
    end else begin : g_inner
      assign next_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occ),
      .prev_lt    (prev_lt),
      .prev_value (prev_value),
      .next_value (next_value),
      .lt         (cell_lt[i]),
      .hit        (cell_hit[i]),
      .value      (cell_value[i])
    );
  end

  // fill count
  always_comb begin
    count_nxt = count_r;
    if (ctrl.push_en) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.pop_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // request side capture: status, popped head and one-hot insertion point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= '0;
    end else if (accept) begin
      hit_r <= cell_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_op == OP_PUSH) begin
        status_r <= is_full ? ST_FULL : ST_DONE;
      end else begin
        status_r <= is_empty ? ST_EMPTY : ST_DONE;
      end
      pop_value_r <= ctrl.pop_en ? cell_value[0] : '0;
    end
  end

  // insertion depth from the registered one-hot position
  spq_depth_enc #(
    .N (CAPACITY)
  ) u_depth_enc (
    .hit (hit_r),
    .pos (pos)
  );

  // depth is reported modulo 32
  assign pos_ext = {{DEPTH_W{1'b0}}, pos};

  // control state machine
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_ENCODE;
        end
      end
      S_ENCODE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= status_r;
      out_value_r  <= pop_value_r;
      out_depth_r  <= pos_ext[DEPTH_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;
  assign out_depth     = out_depth_r;

  // checks
  `SPQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(CAPACITY))
  `SPQ_ASSERT_SAME(a_hit_onehot0, 1'b1, $onehot0(hit_r))
  `SPQ_ASSERT_SAME(a_push_hits_one, ctrl.push_en, $onehot(cell_hit))
  `SPQ_ASSERT_NEXT(a_full_keeps_count, accept && (in_op == OP_PUSH) && is_full,
                   count_r == $past(count_r))

endmodule

FILE: rtl/spq_cell.sv
// one storage cell of the sorted row: holds one value, shifts to its neighbors
// depends on spq_pkg
module spq_cell (
  input  logic                              clk,
  input  spq_pkg::cell_ctrl_t               ctrl,
  input  logic                              occupied,
  input  logic                              prev_lt,
  input  logic signed [spq_pkg::DATA_W-1:0] prev_value,
  input  logic signed [spq_pkg::DATA_W-1:0] next_value,
  output logic                              lt,
  output logic                              hit,
  output logic signed [spq_pkg::DATA_W-1:0] value
);
  import spq_pkg::*;

  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;

  // strictly smaller stored value stays in place on push
  assign lt    = occupied && (value_r < ctrl.key);
  assign hit   = ctrl.push_en && !lt && prev_lt;
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.push_en) begin
      if (!lt) begin
        value_nxt = prev_lt ? ctrl.key : prev_value;
      end
    end else if (ctrl.pop_en) begin
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

FILE: rtl/spq_depth_enc.sv
// one-hot to binary encoder for the insertion position of the cell row
// depends on nothing outside this file
module spq_depth_enc #(
  parameter int N = 16
) (
  input  logic [N-1:0]         hit,
  output logic [$clog2(N)-1:0] pos
);
  localparam int IW = $clog2(N);

  always_comb begin
    pos = '0;
    for (int i = 0; i < N; i++) begin
      if (hit[i]) begin
        pos = pos | IW'(i);
      end
    end
  end

endmodule
